// ===== rtl/gpad_pkg.sv =====
// Shared types, constants and decode helpers for the gamepad change-event block.
package gpad_pkg;

	localparam int unsigned CAPTURE_DEPTH = 17;
	localparam int unsigned POS_W         = 6;
	localparam logic [POS_W-1:0] POS_MAX  = 6'd63;
	localparam int unsigned NUM_BUTTONS   = 11;
	localparam int unsigned NUM_SLOTS     = 16;
	localparam int unsigned SLOT_W        = 4;
	localparam int unsigned QUEUE_DEPTH   = 2;

	// slot numbers in the change mask, in event order
	localparam logic [SLOT_W-1:0] SLOT_TRIG_L  = 4'd11;
	localparam logic [SLOT_W-1:0] SLOT_TRIG_R  = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_STICK_L = 4'd13;
	localparam logic [SLOT_W-1:0] SLOT_STICK_R = 4'd14;
	localparam logic [SLOT_W-1:0] SLOT_DPAD    = 4'd15;

	// capture positions
	localparam int unsigned POS_LX     = 2;
	localparam int unsigned POS_LY     = 4;
	localparam int unsigned POS_RX     = 6;
	localparam int unsigned POS_RY     = 8;
	localparam int unsigned POS_TL_LO  = 9;
	localparam int unsigned POS_TL_HI  = 10;
	localparam int unsigned POS_TR_LO  = 11;
	localparam int unsigned POS_TR_HI  = 12;
	localparam int unsigned POS_DPAD   = 13;
	localparam int unsigned POS_FACE   = 14;
	localparam int unsigned POS_EXTRA  = 15;
	localparam int unsigned POS_UPLOAD = 16;

	typedef enum logic [2:0] {
		EV_BTN_DOWN = 3'd0,
		EV_BTN_UP   = 3'd1,
		EV_TRIGGER  = 3'd2,
		EV_STICK    = 3'd3,
		EV_DPAD     = 3'd4
	} event_kind_t;

	typedef enum logic [7:0] {
		DP_UP         = 8'd1,
		DP_UP_RIGHT   = 8'd2,
		DP_RIGHT      = 8'd3,
		DP_DOWN_RIGHT = 8'd4,
		DP_DOWN       = 8'd5,
		DP_DOWN_LEFT  = 8'd6,
		DP_LEFT       = 8'd7,
		DP_UP_LEFT    = 8'd8
	} dpad_code_t;

	// decoded controls of one report plus which of them changed
	typedef struct packed {
		logic [NUM_SLOTS-1:0]   changed;
		logic [NUM_BUTTONS-1:0] buttons;
		logic [15:0]            trig_l;
		logic [15:0]            trig_r;
		logic [7:0]             lx;
		logic [7:0]             ly;
		logic [7:0]             rx;
		logic [7:0]             ry;
		logic [3:0]             dpad;
	} report_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [3:0] dpad_bits(input logic [7:0] code);
		logic [3:0] r;
		r = 4'h0;
		unique case (code)
			DP_UP:         r = 4'h1;
			DP_UP_RIGHT:   r = 4'h3;
			DP_RIGHT:      r = 4'h2;
			DP_DOWN_RIGHT: r = 4'h6;
			DP_DOWN:       r = 4'h4;
			DP_DOWN_LEFT:  r = 4'hC;
			DP_LEFT:       r = 4'h8;
			DP_UP_LEFT:    r = 4'h9;
			default:       r = 4'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/gpad_front.sv =====
// Front end: byte capture, control decode and change detection against stored controls.
module gpad_front #(
	parameter int unsigned REPORT_LENGTH = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           report_byte,
	input  logic                 end_of_report,
	output logic                 push,
	output gpad_pkg::report_t    push_data
);

	logic [gpad_pkg::POS_W-1:0] pos_q;
	logic [7:0] cap_q [gpad_pkg::CAPTURE_DEPTH];
	logic [7:0] cap_view [gpad_pkg::CAPTURE_DEPTH];
	logic       pos_in_range;

	logic [gpad_pkg::NUM_BUTTONS-1:0] prev_buttons_q;
	logic [15:0] prev_trig_l_q, prev_trig_r_q;
	logic [7:0]  prev_lx_q, prev_ly_q, prev_rx_q, prev_ry_q;
	logic [3:0]  prev_dpad_q;

	gpad_pkg::report_t rep;
	logic [7:0] face, extra;

	assign pos_in_range = (32'(pos_q) < gpad_pkg::CAPTURE_DEPTH) &&
		(32'(pos_q) < REPORT_LENGTH);

	// capture with the current byte folded in, so the closing byte decodes too
	always_comb begin
		for (int i = 0; i < gpad_pkg::CAPTURE_DEPTH; i++) begin
			cap_view[i] = (accept && pos_in_range && (32'(pos_q) == i)) ?
				report_byte : cap_q[i];
		end
	end

	assign face  = cap_view[gpad_pkg::POS_FACE];
	assign extra = cap_view[gpad_pkg::POS_EXTRA];

	always_comb begin
		rep.buttons = {cap_view[gpad_pkg::POS_UPLOAD][0],
			extra[3], extra[2], extra[6], extra[5],
			face[7], face[6], face[0], face[1], face[4], face[3]};
		rep.trig_l = {cap_view[gpad_pkg::POS_TL_HI], cap_view[gpad_pkg::POS_TL_LO]};
		rep.trig_r = {cap_view[gpad_pkg::POS_TR_HI], cap_view[gpad_pkg::POS_TR_LO]};
		rep.lx     = cap_view[gpad_pkg::POS_LX];
		rep.ly     = cap_view[gpad_pkg::POS_LY];
		rep.rx     = cap_view[gpad_pkg::POS_RX];
		rep.ry     = cap_view[gpad_pkg::POS_RY];
		rep.dpad   = gpad_pkg::dpad_bits(cap_view[gpad_pkg::POS_DPAD]);
		rep.changed = {
			rep.dpad != prev_dpad_q,
			(rep.rx != prev_rx_q) || (rep.ry != prev_ry_q),
			(rep.lx != prev_lx_q) || (rep.ly != prev_ly_q),
			rep.trig_r != prev_trig_r_q,
			rep.trig_l != prev_trig_l_q,
			rep.buttons ^ prev_buttons_q};
	end

	assign push      = accept && end_of_report && (rep.changed != '0);
	assign push_data = rep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < gpad_pkg::CAPTURE_DEPTH; i++) cap_q[i] <= '0;
			prev_buttons_q <= '0;
			prev_trig_l_q  <= '0;
			prev_trig_r_q  <= '0;
			prev_lx_q      <= '0;
			prev_ly_q      <= '0;
			prev_rx_q      <= '0;
			prev_ry_q      <= '0;
			prev_dpad_q    <= '0;
		end else if (accept) begin
			if (end_of_report) begin
				pos_q <= '0;
				for (int i = 0; i < gpad_pkg::CAPTURE_DEPTH; i++) cap_q[i] <= '0;
				prev_buttons_q <= rep.buttons;
				prev_trig_l_q  <= rep.trig_l;
				prev_trig_r_q  <= rep.trig_r;
				prev_lx_q      <= rep.lx;
				prev_ly_q      <= rep.ly;
				prev_rx_q      <= rep.rx;
				prev_ry_q      <= rep.ry;
				prev_dpad_q    <= rep.dpad;
			end else begin
				for (int i = 0; i < gpad_pkg::CAPTURE_DEPTH; i++) cap_q[i] <= cap_view[i];
				if (pos_q != gpad_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/gpad_queue.sv =====
// Two-entry queue of decoded reports between the front and back ends.
module gpad_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  gpad_pkg::report_t        push_data,
	input  logic                     pop,
	output gpad_pkg::report_t        pop_data,
	output gpad_pkg::queue_status_t  status
);

	localparam int unsigned PTR_W = $clog2(gpad_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(gpad_pkg::QUEUE_DEPTH + 1);

	gpad_pkg::report_t mem_q [gpad_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (32'(count_q) == gpad_pkg::QUEUE_DEPTH);
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (32'(wr_ptr_q) == gpad_pkg::QUEUE_DEPTH - 1) ?
				'0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (32'(rd_ptr_q) == gpad_pkg::QUEUE_DEPTH - 1) ?
				'0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/gpad_back.sv =====
// Back end: walks a report's change mask, one event per cycle when not stalled.
module gpad_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  gpad_pkg::report_t        q_data,
	output logic                     q_pop,
	output logic                     valid,
	input  logic                     stall,
	output logic [2:0]               event_kind,
	output logic [3:0]               button_index,
	output logic [15:0]              trigger_value,
	output logic [7:0]               stick_x,
	output logic [7:0]               stick_y,
	output logic                     is_left,
	output logic [3:0]               dpad_direction,
	output logic                     last_event
);

	gpad_pkg::report_t               rec_q;
	logic [gpad_pkg::NUM_SLOTS-1:0]  rem_q;
	logic                            busy_q;
	logic                            ov_q;

	logic [gpad_pkg::SLOT_W-1:0]     slot;
	logic [gpad_pkg::NUM_SLOTS-1:0]  low_bit;
	logic                            adv, is_last, load;

	gpad_pkg::event_kind_t kind_d;
	logic [3:0]  btn_d, dpad_d;
	logic [15:0] trig_d;
	logic [7:0]  sx_d, sy_d;
	logic        left_d;

	// lowest pending slot goes first
	always_comb begin
		slot = '0;
		for (int i = gpad_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) slot = gpad_pkg::SLOT_W'(i);
		end
	end

	assign low_bit = gpad_pkg::NUM_SLOTS'(1) << slot;
	assign is_last = ((rem_q & ~low_bit) == '0);
	assign adv     = busy_q && (!ov_q || !stall);
	assign load    = !q_empty && (!busy_q || (adv && is_last));
	assign q_pop   = load;

	always_comb begin
		kind_d = gpad_pkg::EV_BTN_DOWN;
		btn_d  = '0;
		trig_d = '0;
		sx_d   = '0;
		sy_d   = '0;
		left_d = 1'b0;
		dpad_d = '0;
		unique case (slot)
			gpad_pkg::SLOT_TRIG_L: begin
				kind_d = gpad_pkg::EV_TRIGGER;
				trig_d = rec_q.trig_l;
				left_d = 1'b1;
			end
			gpad_pkg::SLOT_TRIG_R: begin
				kind_d = gpad_pkg::EV_TRIGGER;
				trig_d = rec_q.trig_r;
			end
			gpad_pkg::SLOT_STICK_L: begin
				kind_d = gpad_pkg::EV_STICK;
				sx_d   = rec_q.lx;
				sy_d   = rec_q.ly;
				left_d = 1'b1;
			end
			gpad_pkg::SLOT_STICK_R: begin
				kind_d = gpad_pkg::EV_STICK;
				sx_d   = rec_q.rx;
				sy_d   = rec_q.ry;
			end
			gpad_pkg::SLOT_DPAD: begin
				kind_d = gpad_pkg::EV_DPAD;
				dpad_d = rec_q.dpad;
			end
			default: begin
				kind_d = rec_q.buttons[slot] ? gpad_pkg::EV_BTN_DOWN : gpad_pkg::EV_BTN_UP;
				btn_d  = slot;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			rem_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				rem_q  <= q_data.changed;
			end else if (adv) begin
				rem_q <= rem_q & ~low_bit;
				if (is_last) busy_q <= 1'b0;
			end
			if (adv) ov_q <= 1'b1;
			else if (!stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) rec_q <= q_data;
		if (adv) begin
			event_kind     <= kind_d;
			button_index   <= btn_d;
			trigger_value  <= trig_d;
			stick_x        <= sx_d;
			stick_y        <= sy_d;
			is_left        <= left_d;
			dpad_direction <= dpad_d;
			last_event     <= is_last;
		end
	end

	assign valid = ov_q;

endmodule

// ===== rtl/gamepad_report_change_events.sv =====
// Top level: gamepad report decoder that issues change events.
//
//   channel   direction  handshake                 payload
//   request   in         req_valid / req_stall     report_byte, end_of_report
//   event     out        evt_valid / evt_stall     event_kind .. last_event
//
// One report byte is taken per cycle while req_stall is low; the closing byte is
// decoded and compared in the same cycle and, if anything changed, its change set
// goes into a two-entry queue. Events, one per change, leave the event register one
// per cycle while not stalled. req_stall rises only while the queue is full.
// Reset clears the capture, the stored controls, the queue and the event valid flag.
module gamepad_report_change_events #(
	parameter int unsigned REPORT_LENGTH = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  report_byte,
	input  logic        end_of_report,
	output logic        evt_valid,
	input  logic        evt_stall,
	output logic [2:0]  event_kind,
	output logic [3:0]  button_index,
	output logic [15:0] trigger_value,
	output logic [7:0]  stick_x,
	output logic [7:0]  stick_y,
	output logic        is_left,
	output logic [3:0]  dpad_direction,
	output logic        last_event
);

	logic                     accept;
	logic                     q_push, q_pop;
	gpad_pkg::report_t        q_wdata, q_rdata;
	gpad_pkg::queue_status_t  q_status;

	assign req_stall = q_status.full;
	assign accept    = req_valid && !req_stall;

	gpad_front #(
		.REPORT_LENGTH(REPORT_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.report_byte  (report_byte),
		.end_of_report(end_of_report),
		.push         (q_push),
		.push_data    (q_wdata)
	);

	gpad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.status   (q_status)
	);

	gpad_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_status.empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.valid         (evt_valid),
		.stall         (evt_stall),
		.event_kind    (event_kind),
		.button_index  (button_index),
		.trigger_value (trigger_value),
		.stick_x       (stick_x),
		.stick_y       (stick_y),
		.is_left       (is_left),
		.dpad_direction(dpad_direction),
		.last_event    (last_event)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("report pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("report popped from empty queue");

	a_non_button_index: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (event_kind != gpad_pkg::EV_BTN_DOWN) &&
		(event_kind != gpad_pkg::EV_BTN_UP) |-> (button_index == '0))
		else $error("button index on a non-button event");

	a_dpad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (event_kind == gpad_pkg::EV_DPAD) |->
		(trigger_value == '0) && (stick_x == '0) && (stick_y == '0) && !is_left)
		else $error("d-pad event carries trigger or stick data");

endmodule

// ===== test/gamepad_event_check.sv =====
`timescale 1ns / 1ps
// Checker: predicts the change events of each report and compares them with the event channel.
module gamepad_event_check #(
	parameter int unsigned REPORT_LENGTH = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [7:0]  report_byte,
	input  logic        end_of_report,
	input  logic        evt_valid,
	input  logic        evt_stall,
	input  logic [2:0]  event_kind,
	input  logic [3:0]  button_index,
	input  logic [15:0] trigger_value,
	input  logic [7:0]  stick_x,
	input  logic [7:0]  stick_y,
	input  logic        is_left,
	input  logic [3:0]  dpad_direction,
	input  logic        last_event,
	output int          fail_count,
	output int          pending,
	output int          reports_closed,
	output int          events_checked,
	output int          unchanged_reports
);

	typedef struct packed {
		gpad_pkg::event_kind_t kind;
		logic [3:0]  button;
		logic [15:0] trigger;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        left;
		logic [3:0]  dir;
		logic        last;
	} change_event_t;

	change_event_t expected_events[$];

	logic [gpad_pkg::POS_W-1:0]       position = '0;
	logic [7:0]                       capture [gpad_pkg::CAPTURE_DEPTH] = '{default: '0};
	logic [gpad_pkg::NUM_BUTTONS-1:0] held_buttons = '0;
	logic [15:0]                      held_triggers [2] = '{default: '0};
	logic [7:0]                       held_sticks [4] = '{default: '0};
	logic [3:0]                       held_dir = '0;

	int fails = 0;
	int queued = 0;
	int closed = 0;
	int checked = 0;
	int unchanged = 0;

	assign fail_count        = fails;
	assign pending           = queued;
	assign reports_closed    = closed;
	assign events_checked    = checked;
	assign unchanged_reports = unchanged;

	function automatic logic [3:0] direction_of(input logic [7:0] code);
		logic up, right, down, leftward;
		up       = code inside {gpad_pkg::DP_UP, gpad_pkg::DP_UP_RIGHT, gpad_pkg::DP_UP_LEFT};
		right    = code inside {gpad_pkg::DP_UP_RIGHT, gpad_pkg::DP_RIGHT,
			gpad_pkg::DP_DOWN_RIGHT};
		down     = code inside {gpad_pkg::DP_DOWN_RIGHT, gpad_pkg::DP_DOWN,
			gpad_pkg::DP_DOWN_LEFT};
		leftward = code inside {gpad_pkg::DP_DOWN_LEFT, gpad_pkg::DP_LEFT,
			gpad_pkg::DP_UP_LEFT};
		return {leftward, down, right, up};
	endfunction

	task automatic add_event(input gpad_pkg::event_kind_t kind, input logic [3:0] button,
			input logic [15:0] trigger, input logic [7:0] x, input logic [7:0] y,
			input logic left, input logic [3:0] dir);
		change_event_t ev;
		ev.kind    = kind;
		ev.button  = button;
		ev.trigger = trigger;
		ev.x       = x;
		ev.y       = y;
		ev.left    = left;
		ev.dir     = dir;
		ev.last    = 1'b0;
		expected_events.push_back(ev);
	endtask

	task automatic decode_report_byte(input logic [7:0] value, input logic closing);
		logic [gpad_pkg::NUM_BUTTONS-1:0] buttons;
		logic [15:0]                      triggers [2];
		logic [7:0]                       sticks [4];
		logic [3:0]                       dir;
		logic [7:0]                       face, extra, upload;
		int                               first;
		int                               i;
		change_event_t                    tail;
		if (position < gpad_pkg::CAPTURE_DEPTH && position < REPORT_LENGTH)
			capture[position] = value;
		if (position != gpad_pkg::POS_MAX)
			position = position + 1'b1;
		if (closing) begin
			first = expected_events.size();
			face   = capture[gpad_pkg::POS_FACE];
			extra  = capture[gpad_pkg::POS_EXTRA];
			upload = capture[gpad_pkg::POS_UPLOAD];
			// bit order X, Y, B, A, LB, RB, lstick, rstick, menu, view, upload
			buttons = {upload[0], extra[3], extra[2], extra[6], extra[5], face[7],
				face[6], face[0], face[1], face[4], face[3]};
			triggers[0] = {capture[gpad_pkg::POS_TL_HI], capture[gpad_pkg::POS_TL_LO]};
			triggers[1] = {capture[gpad_pkg::POS_TR_HI], capture[gpad_pkg::POS_TR_LO]};
			sticks[0] = capture[gpad_pkg::POS_LX];
			sticks[1] = capture[gpad_pkg::POS_LY];
			sticks[2] = capture[gpad_pkg::POS_RX];
			sticks[3] = capture[gpad_pkg::POS_RY];
			dir = direction_of(capture[gpad_pkg::POS_DPAD]);

			for (i = 0; i < gpad_pkg::NUM_BUTTONS; i++)
				if (buttons[i] != held_buttons[i])
					add_event(buttons[i] ? gpad_pkg::EV_BTN_DOWN : gpad_pkg::EV_BTN_UP,
						4'(i), '0, '0, '0, 1'b0, '0);
			for (i = 0; i < 2; i++)
				if (triggers[i] != held_triggers[i])
					add_event(gpad_pkg::EV_TRIGGER, '0, triggers[i], '0, '0, i == 0, '0);
			for (i = 0; i < 2; i++)
				if (sticks[2*i] != held_sticks[2*i] || sticks[2*i+1] != held_sticks[2*i+1])
					add_event(gpad_pkg::EV_STICK, '0, '0, sticks[2*i], sticks[2*i+1],
						i == 0, '0);
			if (dir != held_dir)
				add_event(gpad_pkg::EV_DPAD, '0, '0, '0, '0, 1'b0, dir);

			if (expected_events.size() > first) begin
				tail = expected_events.pop_back();
				tail.last = 1'b1;
				expected_events.push_back(tail);
			end else begin
				unchanged++;
			end
			closed++;

			held_buttons  = buttons;
			held_triggers = triggers;
			held_sticks   = sticks;
			held_dir      = dir;
			position      = '0;
			for (i = 0; i < gpad_pkg::CAPTURE_DEPTH; i++)
				capture[i] = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: event %0d, %s: got 0x%0h, expected 0x%0h", $time, checked, what, got,
			want);
		fails++;
	endtask

	task automatic check_event();
		change_event_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("event with none pending, kind", event_kind, 0);
		end else begin
			want = expected_events.pop_front();
			if (event_kind != want.kind)
				report_mismatch("event_kind", event_kind, want.kind);
			if (button_index != want.button)
				report_mismatch("button_index", button_index, want.button);
			if (trigger_value != want.trigger)
				report_mismatch("trigger_value", trigger_value, want.trigger);
			if (stick_x != want.x)
				report_mismatch("stick_x", stick_x, want.x);
			if (stick_y != want.y)
				report_mismatch("stick_y", stick_y, want.y);
			if (is_left != want.left)
				report_mismatch("is_left", is_left, want.left);
			if (dpad_direction != want.dir)
				report_mismatch("dpad_direction", dpad_direction, want.dir);
			if (last_event != want.last)
				report_mismatch("last_event", last_event, want.last);
		end
		checked++;
	endtask

	// request first, so a same-edge event would still find its expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_events.delete();
			position      = '0;
			capture       = '{default: '0};
			held_buttons  = '0;
			held_triggers = '{default: '0};
			held_sticks   = '{default: '0};
			held_dir      = '0;
		end else begin
			if (req_valid && !req_stall)
				decode_report_byte(report_byte, end_of_report);
			if (evt_valid && !evt_stall)
				check_event();
		end
		queued = expected_events.size();
	end

endmodule

// ===== test/gamepad_report_change_events_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives report bytes and event back-pressure, and gives the verdict.
module gamepad_report_change_events_test;

	localparam int unsigned REPORT_LEN = 17;
	localparam int          BYTE_BUDGET = 310;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [7:0]  report_byte = '0;
	logic        end_of_report = 1'b0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [3:0]  button_index;
	logic [15:0] trigger_value;
	logic [7:0]  stick_x;
	logic [7:0]  stick_y;
	logic        is_left;
	logic [3:0]  dpad_direction;
	logic        last_event;

	int fail_count;
	int pending;
	int reports_closed;
	int events_checked;
	int unchanged_reports;

	int   bytes_sent = 0;
	int   short_reports = 0;
	int   long_reports = 0;
	int   stall_pct = 25;
	bit   hold_request = 1'b0;
	bit   quiet = 1'b0;
	logic [7:0] frame[$];
	logic [7:0] shadow [gpad_pkg::CAPTURE_DEPTH] = '{default: '0};

	gamepad_report_change_events #(
		.REPORT_LENGTH(REPORT_LEN)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.report_byte   (report_byte),
		.end_of_report (end_of_report),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.event_kind    (event_kind),
		.button_index  (button_index),
		.trigger_value (trigger_value),
		.stick_x       (stick_x),
		.stick_y       (stick_y),
		.is_left       (is_left),
		.dpad_direction(dpad_direction),
		.last_event    (last_event)
	);

	gamepad_event_check #(
		.REPORT_LENGTH(REPORT_LEN)
	) u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.report_byte      (report_byte),
		.end_of_report    (end_of_report),
		.evt_valid        (evt_valid),
		.evt_stall        (evt_stall),
		.event_kind       (event_kind),
		.button_index     (button_index),
		.trigger_value    (trigger_value),
		.stick_x          (stick_x),
		.stick_y          (stick_y),
		.is_left          (is_left),
		.dpad_direction   (dpad_direction),
		.last_event       (last_event),
		.fail_count       (fail_count),
		.pending          (pending),
		.reports_closed   (reports_closed),
		.events_checked   (events_checked),
		.unchanged_reports(unchanged_reports)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d events still pending", pending);
		$display("simulation failed");
		$finish;
	end

	// event back-pressure: random stalls, occasional long runs, one long hold-off
	initial begin
		int hold_left;
		int run_left;
		hold_left = 0;
		run_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				evt_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				evt_stall <= 1'b1;
			end else if ($urandom_range(0, 199) == 0) begin
				run_left = $urandom_range(10, 40);
				evt_stall <= 1'b1;
			end else begin
				evt_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic put_byte(input logic [7:0] value, input logic closing);
		int gap;
		int pick;
		req_valid     <= 1'b1;
		report_byte   <= value;
		end_of_report <= closing;
		do @(posedge clk); while (req_stall);
		bytes_sent++;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(5, 25);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame.size(); i++)
			put_byte(frame[i], i == frame.size() - 1);
	endtask

	initial begin
		int pick;
		int len;
		int idx;
		int n;
		int stall_mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone closing byte at reset state: nothing changes
		frame.delete();
		frame.push_back(8'h00);
		send_frame();
		// every control moves at once: all sixteen events
		frame.delete();
		for (idx = 0; idx < gpad_pkg::CAPTURE_DEPTH; idx++)
			frame.push_back(idx == gpad_pkg::POS_DPAD ? gpad_pkg::DP_UP : 8'hFF);
		send_frame();
		// short report: the missing bytes read as zero, so everything drops back
		frame.delete();
		frame.push_back(8'h5A);
		frame.push_back(8'hA5);
		send_frame();
		short_reports++;

		n = 0;
		while (bytes_sent < BYTE_BUDGET) begin
			quiet = ($urandom_range(0, 4) == 0);
			stall_mode = $urandom_range(0, 4);
			stall_pct = (stall_mode == 0) ? 0 : (stall_mode < 3) ? 15 : 45;
			if (n == 6)
				hold_request = 1'b1;
			pick = (n == 2) ? 99 : $urandom_range(0, 99);
			frame.delete();
			if (pick < 55) begin
				// small edit of the last controls
				repeat ($urandom_range(1, 3)) begin
					idx = $urandom_range(0, gpad_pkg::CAPTURE_DEPTH - 1);
					if (idx == gpad_pkg::POS_DPAD && $urandom_range(0, 3) != 0)
						shadow[idx] = 8'($urandom_range(0, 9));
					else
						shadow[idx] = 8'($urandom);
				end
				for (idx = 0; idx < gpad_pkg::CAPTURE_DEPTH; idx++)
					frame.push_back(shadow[idx]);
			end else if (pick < 65) begin
				for (idx = 0; idx < gpad_pkg::CAPTURE_DEPTH; idx++)
					frame.push_back(shadow[idx]);
			end else if (pick < 75) begin
				for (idx = 0; idx < gpad_pkg::CAPTURE_DEPTH; idx++) begin
					shadow[idx] = 8'($urandom);
					frame.push_back(shadow[idx]);
				end
			end else if (pick < 88) begin
				len = $urandom_range(1, gpad_pkg::CAPTURE_DEPTH - 1);
				for (idx = 0; idx < gpad_pkg::CAPTURE_DEPTH; idx++) begin
					if (idx >= len)
						shadow[idx] = '0;
					else
						frame.push_back(shadow[idx]);
				end
				short_reports++;
			end else begin
				// past 64 bytes the position counter saturates
				len = (n == 2) ? $urandom_range(66, 70) : $urandom_range(18, 40);
				for (idx = 0; idx < len; idx++)
					frame.push_back(idx < gpad_pkg::CAPTURE_DEPTH ? shadow[idx] :
						8'($urandom));
				long_reports++;
			end
			send_frame();
			n++;
		end
		if (req_valid)
			req_valid <= 1'b0;

		@(negedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);

		$display("covered %0d report bytes in %0d reports (%0d short, %0d long, %0d unchanged)",
			bytes_sent, reports_closed, short_reports, long_reports, unchanged_reports);
		$display("checked %0d change events with %0d mismatches", events_checked, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
